// ===== src/ccpp_pkg.sv =====
// Shared types, tag codes and tag size functions for the constant pool parser.
`default_nettype none

package ccpp_pkg;

    // Result queue geometry.
    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_AW    = 3;
    localparam int MAX_RESULTS = 3;

    // Result kinds.
    typedef enum logic [2:0] {
        KIND_ENTRY       = 3'd0,
        KIND_STRING_BYTE = 3'd1,
        KIND_UNUSABLE    = 3'd2,
        KIND_POOL_END    = 3'd3,
        KIND_TAG_ERROR   = 3'd4
    } kind_t;

    // Constant pool tag codes.
    localparam logic [7:0] TAG_UTF8             = 8'd1;
    localparam logic [7:0] TAG_INTEGER          = 8'd3;
    localparam logic [7:0] TAG_FLOAT            = 8'd4;
    localparam logic [7:0] TAG_LONG             = 8'd5;
    localparam logic [7:0] TAG_DOUBLE           = 8'd6;
    localparam logic [7:0] TAG_CLASS            = 8'd7;
    localparam logic [7:0] TAG_STRING           = 8'd8;
    localparam logic [7:0] TAG_FIELDREF         = 8'd9;
    localparam logic [7:0] TAG_METHODREF        = 8'd10;
    localparam logic [7:0] TAG_IFACE_METHODREF  = 8'd11;
    localparam logic [7:0] TAG_NAME_AND_TYPE    = 8'd12;
    localparam logic [7:0] TAG_METHOD_HANDLE    = 8'd15;
    localparam logic [7:0] TAG_METHOD_TYPE      = 8'd16;
    localparam logic [7:0] TAG_INVOKE_DYNAMIC   = 8'd18;

    // One result item.
    typedef struct packed {
        kind_t       kind;
        logic [15:0] slot;
        logic [7:0]  tag;
        logic [31:0] first_value;
        logic [31:0] second_value;
        logic [7:0]  string_byte;
        logic        last;
    } result_t;

    // Results caused by one input byte, handed from the parser to the queue.
    typedef struct packed {
        logic [1:0]                    count;
        result_t [MAX_RESULTS-1:0]     res;
        logic                          at_count_hi;
    } step_out_t;

    // Payload bytes that follow a tag; zero marks an unknown tag.
    function automatic logic [3:0] payload_size(input logic [7:0] tag);
        logic [3:0] size;
        case (tag)
            TAG_UTF8, TAG_CLASS, TAG_STRING, TAG_METHOD_TYPE: size = 4'd2;
            TAG_INTEGER, TAG_FLOAT, TAG_FIELDREF, TAG_METHODREF,
            TAG_IFACE_METHODREF, TAG_NAME_AND_TYPE, TAG_INVOKE_DYNAMIC: size = 4'd4;
            TAG_LONG, TAG_DOUBLE: size = 4'd8;
            TAG_METHOD_HANDLE: size = 4'd3;
            default: size = 4'd0;
        endcase
        return size;
    endfunction

    // Trailing payload bytes that form the second field.
    function automatic logic [3:0] second_size(input logic [7:0] tag);
        logic [3:0] size;
        case (tag)
            TAG_FIELDREF, TAG_METHODREF, TAG_IFACE_METHODREF, TAG_NAME_AND_TYPE,
            TAG_INVOKE_DYNAMIC, TAG_METHOD_HANDLE: size = 4'd2;
            TAG_LONG, TAG_DOUBLE: size = 4'd4;
            default: size = 4'd0;
        endcase
        return size;
    endfunction

endpackage

`default_nettype wire

// ===== src/class_constant_pool_parser.sv =====
// Top level of the constant pool parser: byte input, parser and result queue.
// The block takes one constant pool byte per cycle. Each byte updates the
// parsing state in the same cycle and produces zero to three results (an
// entry, a Utf8 string byte, an unusable slot after a Long or Double, the
// pool end, or an unknown tag error). Results are written into an 8-entry
// result queue and leave it one per cycle, so the output side sets the rate
// whenever bytes produce more than one result each. A byte is taken only
// while the queue has at least three free entries; with a ready output and
// at most one result per byte, input transfers run at one per cycle.
`default_nettype none

module class_constant_pool_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       result_kind,
    output logic [15:0]      slot_index,
    output logic [7:0]       entry_tag,
    output logic [31:0]      first_value,
    output logic [31:0]      second_value,
    output logic [7:0]       string_byte,
    output logic             last
);

    localparam int AW = ccpp_pkg::QUEUE_AW;
    localparam logic [AW:0] READY_LIMIT =
        (AW + 1)'(ccpp_pkg::QUEUE_DEPTH - ccpp_pkg::MAX_RESULTS);

    ccpp_pkg::step_out_t step;
    ccpp_pkg::result_t   queue_mem [ccpp_pkg::QUEUE_DEPTH];
    ccpp_pkg::result_t   head;

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;
    logic          in_fire;
    logic          out_fire;
    logic [1:0]    push_n;

    assign in_ready  = (count_reg <= READY_LIMIT);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = (count_reg != '0);
    assign out_fire  = out_valid && out_ready;
    assign push_n    = in_fire ? step.count : 2'd0;

    ccpp_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .in_byte (in_byte),
        .step    (step)
    );

    // Results of an accepted byte are written at consecutive queue entries.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ccpp_pkg::MAX_RESULTS; i++)
        begin
            if (2'(i) < push_n)
                queue_mem[wr_ptr_reg + AW'(i)] <= step.res[i];
        end
    end

    // Queue pointers and fill count.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + AW'(push_n);
        rd_ptr_next = out_fire ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg + (AW + 1)'(push_n) - (AW + 1)'(out_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // The oldest queued result drives the output fields.
    assign head         = queue_mem[rd_ptr_reg];
    assign result_kind  = head.kind;
    assign slot_index   = head.slot;
    assign entry_tag    = head.tag;
    assign first_value  = head.first_value;
    assign second_value = head.second_value;
    assign string_byte  = head.string_byte;
    assign last         = head.last;

`ifndef NO_ASSERTIONS
    // The queue never holds more results than it has entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (AW + 1)'(ccpp_pkg::QUEUE_DEPTH))
        else $error("result queue overflow");

    // A count high byte produces no result, so the queue does not grow.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && step.at_count_hi) |=> (count_reg <= $past(count_reg)))
        else $error("count high byte produced a result");

    // Pool end is always the final result of its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (result_kind == ccpp_pkg::KIND_POOL_END)) |-> last)
        else $error("pool end not marked last");

    // Only string byte results carry a string byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (result_kind != ccpp_pkg::KIND_STRING_BYTE)) |-> (string_byte == 8'd0))
        else $error("string byte set on another result kind");
`endif

endmodule

`default_nettype wire

// ===== src/ccpp_parser.sv =====
// Byte-level parsing state and the results that one accepted byte produces.
`default_nettype none

module ccpp_parser (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_fire,
    input  wire logic [7:0]          in_byte,
    output ccpp_pkg::step_out_t      step
);

    typedef enum logic [2:0] {
        PH_COUNT_HI = 3'd0,
        PH_COUNT_LO = 3'd1,
        PH_TAG      = 3'd2,
        PH_PAYLOAD  = 3'd3,
        PH_STRING   = 3'd4
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] slots_left_reg, slots_left_next;
    logic [15:0] current_slot_reg, current_slot_next;
    logic [7:0]  current_tag_reg, current_tag_next;
    logic [3:0]  payload_left_reg, payload_left_next;
    logic [31:0] first_acc_reg, first_acc_next;
    logic [31:0] second_acc_reg, second_acc_next;
    logic [15:0] string_left_reg, string_left_next;

    logic [1:0]                                  n_res;
    ccpp_pkg::result_t [ccpp_pkg::MAX_RESULTS-1:0] res;

    // Builds one result with the last flag clear.
    function automatic ccpp_pkg::result_t make_result(
        input ccpp_pkg::kind_t kind,
        input logic [15:0]     slot,
        input logic [7:0]      tag,
        input logic [31:0]     first_value,
        input logic [31:0]     second_value,
        input logic [7:0]      string_byte
    );
        ccpp_pkg::result_t r;
        r.kind         = kind;
        r.slot         = slot;
        r.tag          = tag;
        r.first_value  = first_value;
        r.second_value = second_value;
        r.string_byte  = string_byte;
        r.last         = 1'b0;
        return r;
    endfunction

    // Next state and results for the byte at the input.
    always_comb
    begin
        logic        do_finish;
        logic        wide_tag;
        logic [15:0] count_val;
        logic [3:0]  size;
        logic [3:0]  left_dec;
        logic [15:0] str_dec;
        logic [15:0] adv;

        phase_next        = phase_reg;
        slots_left_next   = slots_left_reg;
        current_slot_next = current_slot_reg;
        current_tag_next  = current_tag_reg;
        payload_left_next = payload_left_reg;
        first_acc_next    = first_acc_reg;
        second_acc_next   = second_acc_reg;
        string_left_next  = string_left_reg;
        n_res             = 2'd0;
        res               = '0;
        do_finish         = 1'b0;
        wide_tag          = (current_tag_reg == ccpp_pkg::TAG_LONG) ||
                            (current_tag_reg == ccpp_pkg::TAG_DOUBLE);
        count_val         = {first_acc_reg[7:0], in_byte};
        size              = ccpp_pkg::payload_size(in_byte);
        left_dec          = (payload_left_reg != 4'd0) ? payload_left_reg - 4'd1 : 4'd0;
        str_dec           = (string_left_reg != 16'd0) ? string_left_reg - 16'd1 : 16'd0;
        adv               = wide_tag ? 16'd2 : 16'd1;

        case (phase_reg)
            PH_COUNT_LO:
            begin
                first_acc_next = '0;
                if (count_val <= 16'd1)
                begin
                    res[n_res] = make_result(ccpp_pkg::KIND_POOL_END, '0, '0, '0, '0, '0);
                    n_res = n_res + 2'd1;
                    phase_next        = PH_COUNT_HI;
                    slots_left_next   = '0;
                    current_slot_next = '0;
                    current_tag_next  = '0;
                    payload_left_next = '0;
                    second_acc_next   = '0;
                    string_left_next  = '0;
                end
                else
                begin
                    slots_left_next   = count_val - 16'd1;
                    current_slot_next = 16'd1;
                    phase_next        = PH_TAG;
                end
            end
            PH_TAG:
            begin
                if (size == 4'd0)
                begin
                    res[n_res] = make_result(ccpp_pkg::KIND_TAG_ERROR, current_slot_reg,
                                             in_byte, '0, '0, '0);
                    n_res = n_res + 2'd1;
                    phase_next        = PH_COUNT_HI;
                    slots_left_next   = '0;
                    current_slot_next = '0;
                    current_tag_next  = '0;
                    payload_left_next = '0;
                    first_acc_next    = '0;
                    second_acc_next   = '0;
                    string_left_next  = '0;
                end
                else
                begin
                    current_tag_next  = in_byte;
                    payload_left_next = size;
                    first_acc_next    = '0;
                    second_acc_next   = '0;
                    phase_next        = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                // Bytes ahead of the second field go into the first field.
                if (payload_left_reg > ccpp_pkg::second_size(current_tag_reg))
                    first_acc_next = {first_acc_reg[23:0], in_byte};
                else
                    second_acc_next = {second_acc_reg[23:0], in_byte};
                payload_left_next = left_dec;
                if (left_dec == 4'd0)
                begin
                    res[n_res] = make_result(ccpp_pkg::KIND_ENTRY, current_slot_reg,
                                             current_tag_reg, first_acc_next,
                                             second_acc_next, '0);
                    n_res = n_res + 2'd1;
                    if (current_tag_reg == ccpp_pkg::TAG_UTF8)
                    begin
                        string_left_next = first_acc_next[15:0];
                        if (first_acc_next[15:0] == 16'd0)
                            do_finish = 1'b1;
                        else
                            phase_next = PH_STRING;
                    end
                    else
                    begin
                        if (wide_tag)
                        begin
                            res[n_res] = make_result(ccpp_pkg::KIND_UNUSABLE,
                                                     current_slot_reg + 16'd1,
                                                     current_tag_reg, '0, '0, '0);
                            n_res = n_res + 2'd1;
                        end
                        do_finish = 1'b1;
                    end
                end
            end
            PH_STRING:
            begin
                res[n_res] = make_result(ccpp_pkg::KIND_STRING_BYTE, current_slot_reg,
                                         current_tag_reg, '0, '0, in_byte);
                n_res = n_res + 2'd1;
                string_left_next = str_dec;
                if (str_dec == 16'd0)
                    do_finish = 1'b1;
            end
            default:
            begin
                first_acc_next = {24'd0, in_byte};
                phase_next     = PH_COUNT_LO;
            end
        endcase

        // Slot completion: advance past the entry, end the pool when none remain.
        if (do_finish)
        begin
            if (slots_left_reg <= adv)
            begin
                res[n_res] = make_result(ccpp_pkg::KIND_POOL_END, '0, '0, '0, '0, '0);
                n_res = n_res + 2'd1;
                phase_next        = PH_COUNT_HI;
                slots_left_next   = '0;
                current_slot_next = '0;
                current_tag_next  = '0;
                payload_left_next = '0;
                first_acc_next    = '0;
                second_acc_next   = '0;
                string_left_next  = '0;
            end
            else
            begin
                slots_left_next   = slots_left_reg - adv;
                current_slot_next = current_slot_reg + adv;
                phase_next        = PH_TAG;
            end
        end

        // The final result of this byte carries the last flag.
        for (int i = 0; i < ccpp_pkg::MAX_RESULTS; i++)
        begin
            res[i].last = (n_res == 2'(i + 1));
        end
    end

    assign step.count       = n_res;
    assign step.res         = res;
    assign step.at_count_hi = (phase_reg == PH_COUNT_HI);

    // Parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_COUNT_HI;
            slots_left_reg   <= '0;
            current_slot_reg <= '0;
            current_tag_reg  <= '0;
            payload_left_reg <= '0;
            first_acc_reg    <= '0;
            second_acc_reg   <= '0;
            string_left_reg  <= '0;
        end
        else if (in_fire)
        begin
            phase_reg        <= phase_next;
            slots_left_reg   <= slots_left_next;
            current_slot_reg <= current_slot_next;
            current_tag_reg  <= current_tag_next;
            payload_left_reg <= payload_left_next;
            first_acc_reg    <= first_acc_next;
            second_acc_reg   <= second_acc_next;
            string_left_reg  <= string_left_next;
        end
    end

endmodule

`default_nettype wire
